// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked only while out of reset.
`define WGA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define WGA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WGA_ASSERT(label, clk, rst_n, prop, msg)
`define WGA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: rtl/wgadj_pkg.sv
// ---------------------------------------------------------------------------
// wgadj_pkg
// Types and fixed constants of the weighted graph adjacency store.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wgadj_pkg;

  localparam int VID_W      = 8;
  localparam int WEIGHT_W   = 32;
  localparam int EDGE_W     = 12;
  localparam int VCOUNT_W   = 9;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 9'd256;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_DUP     = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_DEG_U,
    S_DEG_V,
    S_DEG_W,
    S_SCAN,
    S_WR_U,
    S_WR_V,
    S_RESP,
    S_RD_ISSUE,
    S_RD_LOAD
  } state_t;

  typedef struct packed {
    logic [VID_W-1:0]    nb;
    logic [WEIGHT_W-1:0] wt;
  } row_entry_t;

endpackage

// File: rtl/weighted_graph_adjacency_store.sv
// ---------------------------------------------------------------------------
// weighted_graph_adjacency_store
// Undirected weighted graph held as per-vertex adjacency rows in RAM.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): opcode 0 adds edge (u, v, w),
//    opcode 1 reads the row of u. One item is in flight at a time.
//  - Result channel (out_valid/out_ready): an add gives one result with a
//    status; a read gives one result per row entry, in insertion order, with
//    out_last on the final one. An empty or invalid read gives one result.
//  - Config channel (cfg_valid/cfg_ready) writes vertex_count; always ready.
//  - Add: the time to the result is set by the duplicate scan, which reads
//    one stored neighbor of u per cycle through the one row RAM read port.
//    A failed vertex check skips the scan and goes straight to the result.
//  - Read: one RAM read and one output load per entry; an empty row or an
//    invalid vertex gives its one result without a RAM read.
//  - in_ready returns in the cycle after the last result is loaded.
//  - After reset a clearing pass zeroes every degree RAM entry, with
//    in_ready low. Row RAM contents are not cleared.
//  - A stalled receiver holds the output register; the sequencer waits
//    before loading the next result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module weighted_graph_adjacency_store
  import wgadj_pkg::*;
#(
  parameter int MAX_VERTICES = 256,
  parameter int MAX_DEGREE   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // config write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [VCOUNT_W-1:0] cfg_vertex_count,
  // input items
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  logic [VID_W-1:0]    in_first_vertex,
  input  logic [VID_W-1:0]    in_second_vertex,
  input  logic [WEIGHT_W-1:0] in_edge_weight,
  // results
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic                out_has_entry,
  output logic [VID_W-1:0]    out_neighbor,
  output logic [WEIGHT_W-1:0] out_neighbor_weight,
  output logic                out_last,
  output logic [EDGE_W-1:0]   out_edge_total
);

  // Vertex index, slot index and degree widths. Rows have a power-of-two
  // stride so a row address is just {vertex, slot}.
  localparam int VW     = $clog2(MAX_VERTICES);
  localparam int SW     = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int DGW    = $clog2(MAX_DEGREE + 1);
  localparam int AW     = VW + SW;
  localparam int ROW_DEPTH = MAX_VERTICES * (2 ** SW);

  // ---------------------------------------------------------------- storage
  row_entry_t        row_mem [ROW_DEPTH];
  logic [DGW-1:0]    deg_mem [MAX_VERTICES];

  // ------------------------------------------------------------- registers
  state_t                state_r, state_nxt;
  logic [VW-1:0]         clr_r, clr_nxt;
  logic [VCOUNT_W-1:0]   vcount_r;
  logic [EDGE_W-1:0]     edge_cnt_r, edge_cnt_nxt;

  opcode_t               op_r, op_nxt;
  logic [VID_W-1:0]      u_r, u_nxt;
  logic [VID_W-1:0]      v_r, v_nxt;
  logic [WEIGHT_W-1:0]   w_r, w_nxt;
  logic [DGW-1:0]        du_r, du_nxt;
  logic [DGW-1:0]        dv_r, dv_nxt;
  logic [DGW-1:0]        i_r, i_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  status_t               status_r, status_nxt;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic                  out_has_r, out_has_nxt;
  logic [VID_W-1:0]      out_nb_r, out_nb_nxt;
  logic [WEIGHT_W-1:0]   out_wt_r, out_wt_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [EDGE_W-1:0]     out_edge_r, out_edge_nxt;

  // memory ports
  logic                  row_re, row_we;
  logic [AW-1:0]         row_raddr, row_waddr;
  row_entry_t            row_wdata, row_rdata_r;
  logic                  deg_re, deg_we;
  logic [VW-1:0]         deg_raddr, deg_waddr;
  logic [DGW-1:0]        deg_wdata, deg_rdata_r;

  // --------------------------------------------------------------- decode
  logic          u_ok, v_ok, add_bad, match, scan_done, slot_free, clr_last;
  logic          row_full, out_load, rd_last;
  logic [VW-1:0] uidx, vidx;

  assign uidx      = VW'(u_r);
  assign vidx      = VW'(v_r);
  // a vertex is valid only below both vertex_count and MAX_VERTICES
  assign u_ok      = ({1'b0, u_r} < vcount_r) && (32'(u_r) < MAX_VERTICES);
  assign v_ok      = ({1'b0, v_r} < vcount_r) && (32'(v_r) < MAX_VERTICES);
  assign add_bad   = !u_ok || !v_ok || (u_r == v_r);
  assign match     = cmp_vld_r && (row_rdata_r.nb == v_r);
  assign scan_done = (i_r >= du_r);
  assign row_full  = (du_r >= DGW'(MAX_DEGREE)) || (dv_r >= DGW'(MAX_DEGREE));
  assign slot_free = !out_valid_r || out_ready;
  assign clr_last  = (clr_r == VW'(MAX_VERTICES - 1));
  // entry in row_rdata_r is the final one of the row
  assign rd_last   = ((i_r + DGW'(1)) == du_r);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // ----------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:    if (clr_last) state_nxt = S_IDLE;
      S_IDLE:     if (in_valid) state_nxt = S_CHECK;
      S_CHECK: begin
        if (op_r == OP_ADD) state_nxt = add_bad ? S_RESP : S_DEG_U;
        else                state_nxt = u_ok ? S_DEG_U : S_RESP;
      end
      S_DEG_U:    state_nxt = S_DEG_V;
      S_DEG_V: begin
        if (op_r == OP_ADD)           state_nxt = S_DEG_W;
        else if (deg_rdata_r == '0)   state_nxt = S_RESP;
        else                          state_nxt = S_RD_ISSUE;
      end
      S_DEG_W:    state_nxt = S_SCAN;
      S_SCAN: begin
        if (match)          state_nxt = S_RESP;
        else if (scan_done) state_nxt = row_full ? S_RESP : S_WR_U;
      end
      S_WR_U:     state_nxt = S_WR_V;
      S_WR_V:     state_nxt = S_RESP;
      S_RESP:     if (slot_free) state_nxt = S_IDLE;
      S_RD_ISSUE: state_nxt = S_RD_LOAD;
      S_RD_LOAD: begin
        if (slot_free) state_nxt = rd_last ? S_IDLE : S_RD_ISSUE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // ------------------------------------------------- datapath and outputs
  always_comb begin
    clr_nxt        = clr_r;
    edge_cnt_nxt   = edge_cnt_r;
    op_nxt         = op_r;
    u_nxt          = u_r;
    v_nxt          = v_r;
    w_nxt          = w_r;
    du_nxt         = du_r;
    dv_nxt         = dv_r;
    i_nxt          = i_r;
    cmp_vld_nxt    = cmp_vld_r;
    status_nxt     = status_r;

    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_has_nxt    = out_has_r;
    out_nb_nxt     = out_nb_r;
    out_wt_nxt     = out_wt_r;
    out_last_nxt   = out_last_r;
    out_edge_nxt   = out_edge_r;
    out_load       = 1'b0;

    row_re    = 1'b0;
    row_raddr = {uidx, SW'(i_r)};
    row_we    = 1'b0;
    row_waddr = {uidx, SW'(du_r)};
    row_wdata = '{nb: v_r, wt: w_r};
    deg_re    = 1'b0;
    deg_raddr = uidx;
    deg_we    = 1'b0;
    deg_waddr = uidx;
    deg_wdata = du_r + DGW'(1);

    case (state_r)
      S_CLEAR: begin
        deg_we    = 1'b1;
        deg_waddr = clr_r;
        deg_wdata = '0;
        clr_nxt   = clr_r + VW'(1);
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = opcode_t'(in_opcode);
          u_nxt      = in_first_vertex;
          v_nxt      = in_second_vertex;
          w_nxt      = in_edge_weight;
          status_nxt = ST_OK;
        end
      end
      S_CHECK: begin
        if ((op_r == OP_ADD) ? add_bad : !u_ok) status_nxt = ST_INVALID;
      end
      S_DEG_U: deg_re = 1'b1;
      S_DEG_V: begin
        du_nxt    = deg_rdata_r;
        deg_re    = (op_r == OP_ADD);
        deg_raddr = vidx;
        i_nxt     = '0;
      end
      S_DEG_W: begin
        dv_nxt      = deg_rdata_r;
        i_nxt       = '0;
        cmp_vld_nxt = 1'b0;
      end
      S_SCAN: begin
        // one read issued and one compare done per cycle
        if (match) begin
          status_nxt  = ST_DUP;
          cmp_vld_nxt = 1'b0;
        end else if (!scan_done) begin
          row_re      = 1'b1;
          i_nxt       = i_r + DGW'(1);
          cmp_vld_nxt = 1'b1;
        end else begin
          cmp_vld_nxt = 1'b0;
          if (row_full) status_nxt = ST_FULL;
        end
      end
      S_WR_U: begin
        row_we = 1'b1;
        deg_we = 1'b1;
      end
      S_WR_V: begin
        row_we       = 1'b1;
        row_waddr    = {vidx, SW'(dv_r)};
        row_wdata    = '{nb: u_r, wt: w_r};
        deg_we       = 1'b1;
        deg_waddr    = vidx;
        deg_wdata    = dv_r + DGW'(1);
        edge_cnt_nxt = edge_cnt_r + EDGE_W'(1);
      end
      S_RESP: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_has_nxt    = 1'b0;
          out_nb_nxt     = '0;
          out_wt_nxt     = '0;
          out_last_nxt   = 1'b1;
          out_edge_nxt   = edge_cnt_r;
        end
      end
      S_RD_ISSUE: row_re = 1'b1;
      S_RD_LOAD: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_has_nxt    = 1'b1;
          out_nb_nxt     = row_rdata_r.nb;
          out_wt_nxt     = row_rdata_r.wt;
          out_last_nxt   = rd_last;
          out_edge_nxt   = edge_cnt_r;
          i_nxt          = i_r + DGW'(1);
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      vcount_r    <= VCOUNT_RST;
      edge_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      edge_cnt_r  <= edge_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) vcount_r <= cfg_vertex_count;
    end
  end

  // --------------------------------------------------------- payload regs
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    u_r          <= u_nxt;
    v_r          <= v_nxt;
    w_r          <= w_nxt;
    du_r         <= du_nxt;
    dv_r         <= dv_nxt;
    i_r          <= i_nxt;
    cmp_vld_r    <= cmp_vld_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_has_r    <= out_has_nxt;
    out_nb_r     <= out_nb_nxt;
    out_wt_r     <= out_wt_nxt;
    out_last_r   <= out_last_nxt;
    out_edge_r   <= out_edge_nxt;
  end

  // -------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_waddr] <= row_wdata;
    if (row_re) row_rdata_r <= row_mem[row_raddr];
  end

  always_ff @(posedge clk) begin
    if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
    if (deg_re) deg_rdata_r <= deg_mem[deg_raddr];
  end

  // --------------------------------------------------------------- outputs
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_has_entry       = out_has_r;
  assign out_neighbor        = out_nb_r;
  assign out_neighbor_weight = out_wt_r;
  assign out_last            = out_last_r;
  assign out_edge_total      = out_edge_r;

  // ------------------------------------------------------------ assertions
  `WGA_ASSERT(a_clear_blocks_input, clk, rst_n, (state_r == S_CLEAR) |-> !in_ready, "input transfer during degree clear")
  `WGA_ASSERT(a_load_into_free_slot, clk, rst_n, out_load |-> (!out_valid_r || out_ready), "result overwrites a pending transfer")
  `WGA_ASSERT(a_degree_bound, clk, rst_n, deg_we |-> (deg_wdata <= DGW'(MAX_DEGREE)), "row degree above MAX_DEGREE")
  `WGA_ASSERT(a_edge_count_source, clk, rst_n, !$stable(edge_cnt_r) |-> ($past(state_r) == S_WR_V), "edge count moved outside an edge write")

endmodule
